/* sv/pss_pkg.sv */
// Shared constants, register codes and control bundles for the plucked string synth.
`timescale 1ns / 1ps
`default_nettype none
package pss_pkg;

  localparam int STORE_DEPTH_DEF = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int DL_W       = 20;   // delay_length width, 8 fraction bits
  localparam int LOSS_W     = 16;
  localparam int ALPHA_W    = 17;
  localparam int FRAC_W     = 8;
  localparam int COEF_W     = 18;   // signed multiplier coefficient operand
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int RED_STEPS  = 8;    // restoring steps for delay mod span
  localparam int RED_K_W    = 3;

  localparam logic [DL_W-1:0]    DL_RESET    = 20'd25600;
  localparam logic [LOSS_W-1:0]  LOSS_RESET  = 16'd65012;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;

  localparam logic MODE_LOWPASS = 1'b0;
  localparam logic MODE_PLAIN   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd3;

  typedef struct packed {
    logic load_in;  // take input sample, register read addresses
    logic rd_lo;    // read the two lower taps
    logic rd_hi;    // latch lower taps, read upper tap
    logic interp;   // interpolation product
    logic avg;      // round the tap average
    logic lp_a;     // avg * alpha
    logic lp_b;     // memory * (1 - alpha)
    logic lp_rnd;   // round lowpass, update its memory
    logic loss;     // filtered * loss
    logic finish;   // saturate, write back, present result
  } cmd_t;

  typedef struct packed {
    logic red_busy;
    logic out_busy;
    logic mode;
  } status_t;

endpackage
`default_nettype wire

/* sv/pss_datapath.sv */
// Datapath: config registers, delay store, shared multiplier and result register.
`timescale 1ns / 1ps
`default_nettype none
module pss_datapath #(
  parameter int STORE_DEPTH = pss_pkg::STORE_DEPTH_DEF,
  parameter int SAMPLE_BITS = pss_pkg::SAMPLE_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  pss_pkg::cmd_t                      cmd,
  output pss_pkg::status_t                   status,
  input  wire signed [SAMPLE_BITS-1:0]       excite_sample,
  input  wire                                cfg_we,
  input  wire [pss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [pss_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_sample
);

  localparam int S      = SAMPLE_BITS;
  localparam int AW     = $clog2(STORE_DEPTH);
  localparam int PW     = AW + pss_pkg::FRAC_W;
  localparam int AXW    = PW + 2;
  localparam int CW     = PW + 1 + pss_pkg::RED_STEPS;
  localparam int SPAN_I = STORE_DEPTH * 256;
  localparam int PRW    = S + 1 + pss_pkg::COEF_W;
  localparam logic [AW-1:0] LAST = AW'(STORE_DEPTH - 1);
  localparam logic signed [PRW-1:0] SAT_HI = PRW'((64'sd1 <<< (S - 1)) - 64'sd1);
  localparam logic signed [PRW-1:0] SAT_LO = -SAT_HI - PRW'(1);

  // configuration
  logic [pss_pkg::DL_W-1:0]    rem;     // delay_length reduced mod span
  logic [pss_pkg::LOSS_W-1:0]  loss;
  logic [pss_pkg::ALPHA_W-1:0] alpha;
  logic                        mode;
  logic                        red_busy;
  logic [pss_pkg::RED_K_W-1:0] red_k;
  logic [CW-1:0]               red_sub;

  // loop state
  logic [AW-1:0]         wi;
  logic                  full;
  logic signed [S-1:0]   lpm;

  // per-item registers
  logic signed [S-1:0]          x;
  logic [AW-1:0]                ipp, ip, ipn;
  logic [pss_pkg::FRAC_W-1:0]   frac;
  logic signed [S-1:0]          rd_a, rd_b, pm1, p0;
  logic                         va, vb;
  logic signed [PRW-1:0]        prod, acc, base;
  logic signed [S-1:0]          filt;

  logic signed [S-1:0] mem [STORE_DEPTH];

  // combinational
  logic [AXW-1:0]               pos_t, pos_w;
  logic [AW-1:0]                ip_c, addr_a;
  logic [pss_pkg::ALPHA_W-1:0]  alpha_sat, alpha_c;
  logic signed [S:0]            mul_a;
  logic signed [pss_pkg::COEF_W-1:0] mul_b;
  logic signed [S-1:0]          p1;
  logic signed [PRW-1:0]        avg_t, lp_t, loss_t, y_sum;
  logic signed [S-1:0]          y_sat, avg_r, lp_r;

  assign status.red_busy = red_busy;
  assign status.out_busy = out_valid & out_stall;
  assign status.mode     = mode;

  // read position: wi*256 + span - delay, wrapped into [0, span)
  assign pos_t = AXW'({wi, {pss_pkg::FRAC_W{1'b0}}}) + AXW'(SPAN_I) - AXW'(rem);
  assign pos_w = (pos_t >= AXW'(SPAN_I)) ? pos_t - AXW'(SPAN_I) : pos_t;
  assign ip_c  = pos_w[PW-1:pss_pkg::FRAC_W];

  assign addr_a = cmd.rd_hi ? ipn : ipp;
  assign p1     = va ? rd_a : '0;

  assign alpha_sat = (alpha > pss_pkg::ALPHA_ONE) ? pss_pkg::ALPHA_ONE : alpha;
  assign alpha_c   = pss_pkg::ALPHA_ONE - alpha_sat;

  assign red_sub = CW'(SPAN_I) << red_k;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.interp) begin
      mul_a = (S+1)'(p1) - (S+1)'(pm1);
      mul_b = pss_pkg::COEF_W'(frac);
    end else if (cmd.lp_a) begin
      mul_a = (S+1)'(filt);
      mul_b = pss_pkg::COEF_W'(alpha_sat);
    end else if (cmd.lp_b) begin
      mul_a = (S+1)'(lpm);
      mul_b = pss_pkg::COEF_W'(alpha_c);
    end else if (cmd.loss) begin
      mul_a = (S+1)'(filt);
      mul_b = pss_pkg::COEF_W'(loss);
    end
  end

  // all roundings are floor(v / 2^n + 1/2)
  assign avg_t  = base + prod + PRW'(256);
  assign avg_r  = S'(avg_t >>> 9);
  assign lp_t   = acc + prod + PRW'(32768);
  assign lp_r   = S'(lp_t >>> 16);
  assign loss_t = prod + PRW'(32768);
  assign y_sum  = PRW'(x) + (loss_t >>> 16);
  assign y_sat  = (y_sum > SAT_HI) ? S'(SAT_HI) :
                  (y_sum < SAT_LO) ? S'(SAT_LO) : S'(y_sum);

  // config registers and the delay reducer
  always_ff @(posedge clk) begin
    if (rst) begin
      rem      <= pss_pkg::DL_RESET;
      loss     <= pss_pkg::LOSS_RESET;
      alpha    <= pss_pkg::ALPHA_RESET;
      mode     <= pss_pkg::MODE_LOWPASS;
      red_busy <= 1'b1;
      red_k    <= pss_pkg::RED_K_W'(pss_pkg::RED_STEPS - 1);
    end else if (cfg_we) begin
      case (cfg_index)
        pss_pkg::REG_DELAY: begin
          rem      <= cfg_data[pss_pkg::DL_W-1:0];
          red_busy <= 1'b1;
          red_k    <= pss_pkg::RED_K_W'(pss_pkg::RED_STEPS - 1);
        end
        pss_pkg::REG_LOSS:  loss  <= cfg_data[pss_pkg::LOSS_W-1:0];
        pss_pkg::REG_ALPHA: alpha <= cfg_data[pss_pkg::ALPHA_W-1:0];
        pss_pkg::REG_MODE:  mode  <= cfg_data[0];
        default: ;
      endcase
    end else if (red_busy) begin
      if (CW'(rem) >= red_sub) begin
        rem <= pss_pkg::DL_W'(CW'(rem) - red_sub);
      end
      if (red_k == '0) begin
        red_busy <= 1'b0;
      end else begin
        red_k <= red_k - pss_pkg::RED_K_W'(1);
      end
    end
  end

  // loop state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      wi        <= '0;
      full      <= 1'b0;
      lpm       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.lp_rnd) begin
        lpm <= lp_r;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (wi == LAST) begin
          wi   <= '0;
          full <= 1'b1;
        end else begin
          wi <= wi + AW'(1);
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // per-item payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x    <= excite_sample;
      ip   <= ip_c;
      frac <= pos_w[pss_pkg::FRAC_W-1:0];
      ipp  <= (ip_c == '0) ? LAST : ip_c - AW'(1);
      ipn  <= (ip_c == LAST) ? '0 : ip_c + AW'(1);
    end
    if (cmd.rd_hi) begin
      pm1 <= va ? rd_a : '0;
      p0  <= vb ? rd_b : '0;
    end
    if (cmd.interp) begin
      base <= (PRW'(pm1) + PRW'(p0)) <<< 8;
    end
    if (cmd.interp || cmd.lp_a || cmd.lp_b || cmd.loss) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.lp_b) begin
      acc <= prod;
    end
    if (cmd.avg) begin
      filt <= avg_r;
    end else if (cmd.lp_rnd) begin
      filt <= lp_r;
    end
    if (cmd.finish) begin
      out_sample <= y_sat;
    end
  end

  // delay store: two read ports, one write port; unwritten slots read as zero
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      mem[wi] <= y_sat;
    end
    if (cmd.rd_lo || cmd.rd_hi) begin
      rd_a <= mem[addr_a];
      va   <= full || (addr_a < wi);
    end
    if (cmd.rd_lo) begin
      rd_b <= mem[ip];
      vb   <= full || (ip < wi);
    end
  end

endmodule
`default_nettype wire

/* sv/pss_ctrl.sv */
// Controller: sequences one sample through reads, multiplies and write-back.
`timescale 1ns / 1ps
`default_nettype none
module pss_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  pss_pkg::status_t  status,
  output pss_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_INTERP,
    ST_AVG,
    ST_LP_A,
    ST_LP_B,
    ST_LP_RND,
    ST_LOSS,
    ST_FINISH
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != ST_IDLE) || status.red_busy;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load_in = 1'b1;
          state_next  = ST_RD0;
        end
      end
      ST_RD0: begin
        cmd.rd_lo  = 1'b1;
        state_next = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_hi  = 1'b1;
        state_next = ST_INTERP;
      end
      ST_INTERP: begin
        cmd.interp = 1'b1;
        state_next = ST_AVG;
      end
      ST_AVG: begin
        cmd.avg    = 1'b1;
        state_next = (status.mode == pss_pkg::MODE_PLAIN) ? ST_LOSS : ST_LP_A;
      end
      ST_LP_A: begin
        cmd.lp_a   = 1'b1;
        state_next = ST_LP_B;
      end
      ST_LP_B: begin
        cmd.lp_b   = 1'b1;
        state_next = ST_LP_RND;
      end
      ST_LP_RND: begin
        cmd.lp_rnd = 1'b1;
        state_next = ST_LOSS;
      end
      ST_LOSS: begin
        cmd.loss   = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* sv/plucked_string_synth.sv */
// Top level of the plucked string synth: config port, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Karplus-Strong plucked string voice. Each excite_sample request yields one
// out_sample. A request is taken only in the idle state. The sequencer reads
// three store taps through the two read ports in its ST_RD0 and ST_RD1 states,
// then steps one shared multiplier through interpolation, the lowpass pair (only
// with the one-pole lowpass on, mode 0; skipped in plain average mode) and
// the loss scaling. The result sits in an output register; the next request
// may be taken while it waits, but its write-back holds until the result is
// taken. After reset, and after every delay_length write, input stalls while
// delay_length is reduced modulo STORE_DEPTH*256 by restoring subtraction.
// The delay store needs no clearing pass: slots are written in order from
// zero, so a slot not yet reached since reset reads as zero. Config writes
// are always taken (cfg_ready tied high) and must only be issued while no
// request is in flight.
module plucked_string_synth #(
  parameter int STORE_DEPTH = pss_pkg::STORE_DEPTH_DEF,
  parameter int SAMPLE_BITS = pss_pkg::SAMPLE_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  // sample in
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire signed [SAMPLE_BITS-1:0]    excite_sample,
  // sample out
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic signed [SAMPLE_BITS-1:0]   out_sample,
  // config writes
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [pss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [pss_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pss_pkg::cmd_t    cmd;
  pss_pkg::status_t status;
  logic             cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  pss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pss_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .excite_sample (excite_sample),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample    (out_sample)
  );

endmodule
`default_nettype wire

/* tb/plucked_string_synth_tb.sv */
// Self-checking testbench for the plucked string synth: predictor, stimulus, checks.
`timescale 1ns / 1ps

// Each accepted excite_sample request is run through a bit-exact copy of the
// string loop: delay line, two-tap interpolation, tap average, optional
// one-pole lowpass, loss scaling and saturation. The predicted out_sample is
// queued and every accepted result is compared with the oldest entry.
// Register writes are issued only with the pipeline drained. Stimulus is a
// short directed pass, then random phases of plucks with random settings.
module plucked_string_synth_tb;

  localparam int SBITS          = pss_pkg::SAMPLE_BITS_DEF;
  localparam int FRAC_W         = pss_pkg::FRAC_W;
  localparam int DL_W           = pss_pkg::DL_W;
  localparam int LOSS_W         = pss_pkg::LOSS_W;
  localparam int ALPHA_W        = pss_pkg::ALPHA_W;
  localparam int CFG_IDX_W      = pss_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W     = pss_pkg::CFG_DATA_W;
  localparam int TOTAL_ITEMS    = 1750;
  localparam int SETTLE_CYCLES  = 24;    // request latency plus delay reduction
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all
  localparam int MAX_SHOWN      = 40;    // mismatch lines printed before going quiet

  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_LONG, STALL_TOGGLE} stall_kind_t;

  // Predictor and scoreboard for the string loop.
  class string_tracker;
    localparam int DEPTH = pss_pkg::STORE_DEPTH_DEF;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = AW + FRAC_W;
    localparam int Q16   = 16;
    localparam longint SAT_HI = (longint'(1) <<< (SBITS - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam longint UNITY  = longint'(pss_pkg::ALPHA_ONE);

    logic signed [SBITS-1:0] echo_line [DEPTH];
    logic [AW-1:0]           head;
    longint                  lp_state;
    logic [DL_W-1:0]         delay_q8;
    logic [LOSS_W-1:0]       loss;
    logic [ALPHA_W-1:0]      alpha;
    logic                    mode;
    logic signed [SBITS-1:0] want_samples [$];
    int                      errors;
    int                      compared;
    int                      shown;

    function new();
      foreach (echo_line[i]) echo_line[i] = '0;
      head     = '0;
      lp_state = 0;
      delay_q8 = pss_pkg::DL_RESET;
      loss     = pss_pkg::LOSS_RESET;
      alpha    = pss_pkg::ALPHA_RESET;
      mode     = pss_pkg::MODE_LOWPASS;
      errors   = 0;
      compared = 0;
      shown    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        pss_pkg::REG_DELAY: delay_q8 = d[DL_W-1:0];
        pss_pkg::REG_LOSS:  loss     = d[LOSS_W-1:0];
        pss_pkg::REG_ALPHA: alpha    = d[ALPHA_W-1:0];
        pss_pkg::REG_MODE:  mode     = d[0];
        default: ;
      endcase
    endfunction

    // floor(v / 2^n + 1/2)
    function longint half_up(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // tap value times 256, between slot i and the slot after it
    function longint tap(logic [AW-1:0] i, logic [FRAC_W-1:0] f);
      logic [AW-1:0] nx;
      longint p, q, fr;
      nx = i + 1'b1;
      p  = echo_line[i];
      q  = echo_line[nx];
      fr = f;
      return (p <<< FRAC_W) + fr * (q - p);
    endfunction

    function void take_excite(logic signed [SBITS-1:0] x);
      logic [PW-1:0]     pos;
      logic [AW-1:0]     ip, ipp;
      logic [FRAC_W-1:0] fr;
      longint xv, avg, filt, a, lv, y;
      // taps are read before this sample is written back
      pos = {head, {FRAC_W{1'b0}}} - delay_q8;
      ip  = pos[PW-1:FRAC_W];
      fr  = pos[FRAC_W-1:0];
      ipp = ip - 1'b1;
      avg = half_up(tap(ip, fr) + tap(ipp, fr), FRAC_W + 1);
      if (mode == pss_pkg::MODE_LOWPASS) begin
        a = (alpha > pss_pkg::ALPHA_ONE) ? UNITY : longint'(alpha);
        filt = half_up(avg * a + lp_state * (UNITY - a), Q16);
        lp_state = filt;
      end else begin
        filt = avg;
      end
      lv = loss;
      xv = x;
      y  = xv + half_up(filt * lv, Q16);
      if (y > SAT_HI) y = SAT_HI;
      else if (y < SAT_LO) y = SAT_LO;
      echo_line[head] = y[SBITS-1:0];
      head = head + 1'b1;
      want_samples.push_back(y[SBITS-1:0]);
    endfunction

    task report(string msg);
      errors++;
      if (shown < MAX_SHOWN) begin
        shown++;
        $display("[%0t] ERROR %s", $time, msg);
      end
    endtask

    task check_out(logic signed [SBITS-1:0] got);
      logic signed [SBITS-1:0] want;
      if (want_samples.size() == 0) begin
        report($sformatf("out_sample %0d with no request pending", got));
        return;
      end
      want = want_samples.pop_front();
      compared++;
      if (got !== want)
        report($sformatf("out_sample #%0d: got %0d, expected %0d", compared, got, want));
    endtask

    task flush();
      if (want_samples.size() != 0)
        report($sformatf("%0d expected out_samples never arrived", want_samples.size()));
    endtask
  endclass

  logic                    clk;
  logic                    rst           = 1'b1;
  logic                    in_valid      = 1'b0;
  logic                    in_stall;
  logic signed [SBITS-1:0] excite_sample = '0;
  logic                    out_valid;
  logic                    out_stall     = 1'b0;
  logic signed [SBITS-1:0] out_sample;
  logic                    cfg_valid     = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index     = '0;
  logic [CFG_DATA_W-1:0]   cfg_data      = '0;

  string_tracker sb = new();

  int          burst_left    = 0;
  int          items_sent    = 0;
  int          settings_used = 0;
  int          quiet_cycles  = 0;
  int          pat_left      = 0;
  stall_kind_t pat_kind      = STALL_NONE;

  plucked_string_synth dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .excite_sample (excite_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample    (out_sample),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --- monitors: sample handshakes at the edge, before any update lands ---

  // prediction is made when the request is taken
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.take_excite(excite_sample);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_out(out_sample);
  end

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
  end

  // Receiver back-pressure: a random pattern, held until its countdown ends,
  // from never stalling through sparse stalls and long runs to toggling.
  always @(posedge clk) begin
    if (pat_left == 0) begin
      pat_kind <= stall_kind_t'($urandom_range(0, 3));
      pat_left <= $urandom_range(32, 256);
    end else begin
      pat_left <= pat_left - 1;
    end
    case (pat_kind)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_SPARSE: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_LONG:   if ($urandom_range(0, 15) == 0) out_stall <= ~out_stall;
      default:      out_stall <= ~out_stall;
    endcase
  end

  // Watchdog: any handshake at all resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: %0d cycles without any handshake", quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // --- drivers: every task starts and ends at a rising edge ---

  // One excite request. The sender runs in bursts; between bursts it may
  // drop valid for a random gap. Valid stays high across back-to-back requests.
  task automatic push_sample(input logic signed [SBITS-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = 0;
        9:             gap = $urandom_range(10, 30);
        default:       gap = $urandom_range(1, 8);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    excite_sample <= v;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sender pauses until every predicted sample is back, then lets the
  // pipeline settle so a register write finds the block idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.want_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers; unused upper data bits carry junk.
  task automatic apply_setting(input logic [DL_W-1:0] dl, input logic [LOSS_W-1:0] ls,
                               input logic [ALPHA_W-1:0] al, input logic md);
    logic [CFG_DATA_W-1:0] d;
    write_reg(pss_pkg::REG_DELAY, CFG_DATA_W'(dl));
    d = CFG_DATA_W'($urandom);
    d[LOSS_W-1:0] = ls;
    write_reg(pss_pkg::REG_LOSS, d);
    d = CFG_DATA_W'($urandom);
    d[ALPHA_W-1:0] = al;
    write_reg(pss_pkg::REG_ALPHA, d);
    d = CFG_DATA_W'($urandom);
    d[0] = md;
    write_reg(pss_pkg::REG_MODE, d);
    settings_used++;
  endtask

  // --- main sequence ---
  initial begin
    logic [DL_W-1:0]         dl;
    logic [LOSS_W-1:0]       ls;
    logic [ALPHA_W-1:0]      al;
    logic                    md;
    logic signed [SBITS-1:0] v;
    int n_items, ring, pluck_len, since, roll;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings over an empty store: extremes and bit patterns.
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh0000);
    push_sample(-16'sd1);
    push_sample(16'sd1);
    push_sample(16'sh5555);
    push_sample(16'shAAAA);
    wait_idle();

    // Zero delay: the current slot is read one lap old. Full loss gain
    // drives the loop into saturation at both rails.
    apply_setting('0, '1, pss_pkg::ALPHA_ONE, pss_pkg::MODE_LOWPASS);
    repeat (4) push_sample(16'sh7FFF);
    repeat (4) push_sample(16'sh8000);
    wait_idle();

    // Fractional delay, alpha above one, plain average (lowpass state held).
    apply_setting(DL_W'(640), 16'h8000, '1, pss_pkg::MODE_PLAIN);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh4000);
    push_sample(-16'sh4000);
    push_sample(16'sh0000);
    wait_idle();

    // Longest delay, alpha zero: the lowpass replays the memory kept
    // from before the plain-average phase.
    apply_setting('1, '1, '0, pss_pkg::MODE_LOWPASS);
    push_sample(16'sh0000);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sd1);
    wait_idle();

    // Random phases: each gets a fresh setting, then plucks (a noise burst
    // then mostly silence so the string rings) with some noise and extremes.
    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       dl = '0;
        1:       dl = DL_W'($urandom_range(1, 511));
        2:       dl = DL_W'(512);
        3:       dl = '1;
        4:       dl = DL_W'($urandom);
        default: dl = DL_W'($urandom_range(512, 64 * 256));
      endcase
      case ($urandom_range(0, 5))
        0:       ls = '0;
        1:       ls = '1;
        2:       ls = LOSS_W'($urandom);
        default: ls = LOSS_W'($urandom_range(60000, 65535));
      endcase
      case ($urandom_range(0, 7))
        0:       al = '0;
        1:       al = pss_pkg::ALPHA_ONE;
        2:       al = '1;
        3:       al = ALPHA_W'($urandom_range(65537, 131071));
        4:       al = ALPHA_W'($urandom);
        default: al = ALPHA_W'($urandom_range(16384, 65536));
      endcase
      md = ($urandom_range(0, 1) == 0) ? pss_pkg::MODE_LOWPASS : pss_pkg::MODE_PLAIN;
      apply_setting(dl, ls, al, md);

      n_items = $urandom_range(90, 160);
      ring    = 0;
      since   = 0;
      pluck_len = 1;
      for (int k = 0; k < n_items; k++) begin
        if (ring == 0) begin
          ring      = $urandom_range(30, 150);
          pluck_len = $urandom_range(1, 48);
          since     = 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          case ($urandom_range(0, 3))
            0:       v = 16'sh7FFF;
            1:       v = 16'sh8000;
            2:       v = '0;
            default: v = '1;
          endcase
        end else if (roll < 12 || since < pluck_len) begin
          v = SBITS'($urandom);
        end else if (roll < 75) begin
          v = '0;
        end else begin
          v = SBITS'(int'($urandom_range(0, 511)) - 256);
        end
        push_sample(v);
        since++;
        ring--;
      end
      wait_idle();
    end

    sb.flush();
    $display("Drove %0d excite samples across %0d register settings (delay zero to max,",
             items_sent, settings_used);
    $display("loss 0 to full, alpha up to 2^17-1, both modes); %0d outputs checked, %0d errors.",
             sb.compared, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
